// ----- rtl/core/sic_pkg.sv -----
// shared types and constants of the sequence id checker
package sic_pkg;

    localparam int NUM_TYPES_DEFAULT = 6;
    localparam int TYPE_W = 4;
    localparam int ID_W = 16;
    localparam int CNT_W = 32;

    typedef enum logic [1:0] {
        ST_IN_ORDER  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_GAP       = 2'd2,
        ST_INVALID   = 2'd3
    } sic_status_t;

    typedef struct packed {
        logic [ID_W-1:0]  expected;
        logic [ID_W-1:0]  last;
        logic [CNT_W-1:0] missed;
        logic [CNT_W-1:0] dup;
    } sic_entry_t;

    typedef struct packed {
        logic             accepted;
        sic_status_t      status;
        logic [ID_W-1:0]  gap;
    } sic_verdict_t;

endpackage

// ----- rtl/core/sic_state.sv -----
// per-type tracking registers and the shared invalid counter
module sic_state
    import sic_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEFAULT,
    parameter int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] rd_idx,
    output sic_entry_t       rd_entry,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  sic_entry_t       wr_entry,
    input  logic             inv_inc,
    output logic [CNT_W-1:0] inv_count
);

    sic_entry_t       entry_reg [NUM_TYPES];
    logic [CNT_W-1:0] inv_reg;
    logic [CNT_W-1:0] inv_next;

    assign inv_next  = inv_reg + CNT_W'(1);
    assign inv_count = inv_reg;
    assign rd_entry  = entry_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                entry_reg[i] <= '0;
            end
            inv_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_reg[wr_idx] <= wr_entry;
            end
            if (inv_inc)
            begin
                inv_reg <= inv_next;
            end
        end
    end

endmodule

// ----- rtl/core/sic_eval.sv -----
// compare one sequence id with its type's expectation and form the updated entry
module sic_eval
    import sic_pkg::*;
(
    input  logic [ID_W-1:0] seq_id,
    input  sic_entry_t      cur,
    output sic_entry_t      upd,
    output sic_verdict_t    verdict
);

    logic [ID_W-1:0] diff;
    logic [ID_W-1:0] id_inc;

    assign diff   = seq_id - cur.expected;
    assign id_inc = seq_id + ID_W'(1);

    always_comb
    begin
        upd = cur;
        verdict.accepted = 1'b0;
        verdict.status   = ST_DUPLICATE;
        verdict.gap      = '0;
        if (seq_id == cur.expected)
        begin
            upd.last         = seq_id;
            upd.expected     = id_inc;
            verdict.accepted = 1'b1;
            verdict.status   = ST_IN_ORDER;
        end
        else if (seq_id < cur.expected)
        begin
            upd.dup = cur.dup + CNT_W'(1);
        end
        else
        begin
            upd.missed       = cur.missed + CNT_W'(diff);
            upd.last         = seq_id;
            upd.expected     = id_inc;
            verdict.accepted = 1'b1;
            verdict.status   = ST_GAP;
            verdict.gap      = diff;
        end
    end

endmodule

// ----- rtl/core/sequence_id_checker_core.sv -----
// top level of the sequence id checker
//
// Requests arrive on the input channel (in_valid/in_ready) carrying pkt_type
// and seq_id. Each request produces exactly one result on the output channel
// (out_valid/out_ready) with the verdict and the updated per-type counters.
// A request is first captured in an input register; once the output register
// is free or being drained, the per-type entry is read, compared and written
// back while the result is loaded into the output register, which holds it
// with out_valid high until it is taken. One request can be taken every
// cycle as long as the receiver keeps out_ready high. The state update of
// one request is written at the same edge the next request is captured, so
// back to back requests of the same type see each other without stalls.
// When the receiver stalls, the result holds in the output register and one
// more request can still be captured; after that in_ready drops until the
// output drains. Reset clears all expected ids, last ids and counters, and
// empties both registers.
module sequence_id_checker_core
    import sic_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TYPE_W-1:0] pkt_type,
    input  logic [ID_W-1:0]   seq_id,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              accepted,
    output logic [1:0]        status,
    output logic [ID_W-1:0]   gap_size,
    output logic [ID_W-1:0]   expected_next,
    output logic [ID_W-1:0]   last_valid,
    output logic [CNT_W-1:0]  missed_total,
    output logic [CNT_W-1:0]  duplicate_total,
    output logic [CNT_W-1:0]  invalid_total
);

    localparam int IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

    logic              req_valid_reg;
    logic [TYPE_W-1:0] req_type_reg;
    logic [ID_W-1:0]   req_id_reg;

    logic              out_valid_reg;
    logic              accepted_reg;
    sic_status_t       status_reg;
    logic [ID_W-1:0]   gap_reg;
    logic [ID_W-1:0]   expected_reg;
    logic [ID_W-1:0]   last_reg;
    logic [CNT_W-1:0]  missed_reg;
    logic [CNT_W-1:0]  dup_reg;
    logic [CNT_W-1:0]  inv_reg;

    logic              advance;
    logic              type_ok;
    logic [IDX_W-1:0]  idx;
    sic_entry_t        cur_entry;
    sic_entry_t        upd_entry;
    sic_verdict_t      verdict;
    logic [CNT_W-1:0]  inv_count;

    assign advance  = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || advance;
    assign type_ok  = ({1'b0, req_type_reg} < (TYPE_W + 1)'(NUM_TYPES));
    assign idx      = req_type_reg[IDX_W-1:0];

    sic_state #(
        .NUM_TYPES (NUM_TYPES),
        .IDX_W     (IDX_W)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_idx    (idx),
        .rd_entry  (cur_entry),
        .wr_en     (advance && type_ok),
        .wr_idx    (idx),
        .wr_entry  (upd_entry),
        .inv_inc   (advance && !type_ok),
        .inv_count (inv_count)
    );

    sic_eval u_eval (
        .seq_id  (req_id_reg),
        .cur     (cur_entry),
        .upd     (upd_entry),
        .verdict (verdict)
    );

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_type_reg <= pkt_type;
            req_id_reg   <= seq_id;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (type_ok)
            begin
                accepted_reg <= verdict.accepted;
                status_reg   <= verdict.status;
                gap_reg      <= verdict.gap;
                expected_reg <= upd_entry.expected;
                last_reg     <= upd_entry.last;
                missed_reg   <= upd_entry.missed;
                dup_reg      <= upd_entry.dup;
                inv_reg      <= inv_count;
            end
            else
            begin
                accepted_reg <= 1'b0;
                status_reg   <= ST_INVALID;
                gap_reg      <= '0;
                expected_reg <= '0;
                last_reg     <= '0;
                missed_reg   <= '0;
                dup_reg      <= '0;
                inv_reg      <= inv_count + CNT_W'(1);
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign accepted        = accepted_reg;
    assign status          = status_reg;
    assign gap_size        = gap_reg;
    assign expected_next   = expected_reg;
    assign last_valid      = last_reg;
    assign missed_total    = missed_reg;
    assign duplicate_total = dup_reg;
    assign invalid_total   = inv_reg;

    a_accept_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == ((status == ST_IN_ORDER) || (status == ST_GAP))))
        else $error("accepted flag disagrees with status");

    a_gap_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_GAP)) |-> (gap_size == '0))
        else $error("nonzero gap outside gap status");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_INVALID)) |->
            ((expected_next == '0) && (last_valid == '0) && (missed_total == '0)))
        else $error("invalid type result carries per-type state");

    a_expect_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (expected_next == last_valid + ID_W'(1)))
        else $error("expected id does not follow last accepted id");

endmodule

// ----- tb/sv/sic_result_checker.sv -----
// result checker for the sequence id checker: predicts each result and compares it
module sic_result_checker
    import sic_pkg::*;
#(
    parameter int NUM_TYPES = NUM_TYPES_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [TYPE_W-1:0] pkt_type,
    input  logic [ID_W-1:0]   seq_id,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              accepted,
    input  logic [1:0]        status,
    input  logic [ID_W-1:0]   gap_size,
    input  logic [ID_W-1:0]   expected_next,
    input  logic [ID_W-1:0]   last_valid,
    input  logic [CNT_W-1:0]  missed_total,
    input  logic [CNT_W-1:0]  duplicate_total,
    input  logic [CNT_W-1:0]  invalid_total,
    output int                mismatch_count,
    output int                pending_count,
    output int                checked_count
);

    typedef struct packed {
        logic             accepted;
        sic_status_t      status;
        logic [ID_W-1:0]  gap;
        logic [ID_W-1:0]  next_id;
        logic [ID_W-1:0]  last_id;
        logic [CNT_W-1:0] missed;
        logic [CNT_W-1:0] dup;
        logic [CNT_W-1:0] bad_types;
    } sic_result_t;

    logic [ID_W-1:0]  next_id_tbl [NUM_TYPES];
    logic [ID_W-1:0]  last_id_tbl [NUM_TYPES];
    logic [CNT_W-1:0] missed_tbl [NUM_TYPES];
    logic [CNT_W-1:0] dup_tbl [NUM_TYPES];
    logic [CNT_W-1:0] bad_type_cnt;
    sic_result_t      pending_verdicts [$];

    function automatic sic_result_t predict_verdict(input logic [TYPE_W-1:0] t,
                                                    input logic [ID_W-1:0] id);
        sic_result_t r;
        int k;
        r = '0;
        if (t >= NUM_TYPES) begin
            bad_type_cnt = bad_type_cnt + 1'b1;
            r.status = ST_INVALID;
            r.bad_types = bad_type_cnt;
            return r;
        end
        k = int'(t);
        if (id == next_id_tbl[k]) begin
            last_id_tbl[k] = id;
            next_id_tbl[k] = id + 1'b1;
            r.accepted = 1'b1;
            r.status = ST_IN_ORDER;
        end
        else if (id < next_id_tbl[k]) begin
            dup_tbl[k] = dup_tbl[k] + 1'b1;
            r.status = ST_DUPLICATE;
        end
        else begin
            r.gap = id - next_id_tbl[k];
            missed_tbl[k] = missed_tbl[k] + CNT_W'(r.gap);
            last_id_tbl[k] = id;
            next_id_tbl[k] = id + 1'b1;
            r.accepted = 1'b1;
            r.status = ST_GAP;
        end
        r.next_id = next_id_tbl[k];
        r.last_id = last_id_tbl[k];
        r.missed = missed_tbl[k];
        r.dup = dup_tbl[k];
        r.bad_types = bad_type_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sic_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < NUM_TYPES; i++) begin
                next_id_tbl[i] = '0;
                last_id_tbl[i] = '0;
                missed_tbl[i] = '0;
                dup_tbl[i] = '0;
            end
            bad_type_cnt = '0;
            pending_verdicts.delete();
            mismatch_count = 0;
            checked_count = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (pending_verdicts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result with no request waiting: status %0d", status);
                end
                else begin
                    want = pending_verdicts.pop_front();
                    checked_count++;
                    check_field("accepted", CNT_W'(want.accepted), CNT_W'(accepted));
                    check_field("status", CNT_W'(want.status), CNT_W'(status));
                    check_field("gap_size", CNT_W'(want.gap), CNT_W'(gap_size));
                    check_field("expected_next", CNT_W'(want.next_id),
                                CNT_W'(expected_next));
                    check_field("last_valid", CNT_W'(want.last_id), CNT_W'(last_valid));
                    check_field("missed_total", want.missed, missed_total);
                    check_field("duplicate_total", want.dup, duplicate_total);
                    check_field("invalid_total", want.bad_types, invalid_total);
                end
            end
            if (in_valid && in_ready)
                pending_verdicts.push_back(predict_verdict(pkt_type, seq_id));
        end
        pending_count = pending_verdicts.size();
    end

endmodule

// ----- tb/sv/tb_sequence_id_checker_core.sv -----
// testbench top of the sequence id checker: stimulus, idle mixes and verdict
module tb_sequence_id_checker_core;
    import sic_pkg::*;

    localparam int NUM_TYPES = NUM_TYPES_DEFAULT;
    localparam int STALL_LIMIT = 5000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [TYPE_W-1:0] pkt_type;
    logic [ID_W-1:0]   seq_id;
    logic              out_valid;
    logic              out_ready;
    logic              accepted;
    logic [1:0]        status;
    logic [ID_W-1:0]   gap_size;
    logic [ID_W-1:0]   expected_next;
    logic [ID_W-1:0]   last_valid;
    logic [CNT_W-1:0]  missed_total;
    logic [CNT_W-1:0]  duplicate_total;
    logic [CNT_W-1:0]  invalid_total;

    int mismatch_count;
    int pending_count;
    int checked_count;
    int send_idle_pct;
    int recv_idle_pct;
    int unsigned stall_cycles;
    int directed_sent;
    int random_sent;
    logic [ID_W-1:0] stim_next [NUM_TYPES];

    sequence_id_checker_core #(
        .NUM_TYPES(NUM_TYPES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pkt_type(pkt_type),
        .seq_id(seq_id),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .accepted(accepted),
        .status(status),
        .gap_size(gap_size),
        .expected_next(expected_next),
        .last_valid(last_valid),
        .missed_total(missed_total),
        .duplicate_total(duplicate_total),
        .invalid_total(invalid_total)
    );

    sic_result_checker #(
        .NUM_TYPES(NUM_TYPES)
    ) u_result_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .pkt_type(pkt_type),
        .seq_id(seq_id),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .accepted(accepted),
        .status(status),
        .gap_size(gap_size),
        .expected_next(expected_next),
        .last_valid(last_valid),
        .missed_total(missed_total),
        .duplicate_total(duplicate_total),
        .invalid_total(invalid_total),
        .mismatch_count(mismatch_count),
        .pending_count(pending_count),
        .checked_count(checked_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_sequence_id_checker_core NOT OK");
            $finish;
        end
    end

    task automatic send_request(input logic [TYPE_W-1:0] t, input logic [ID_W-1:0] id);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pkt_type <= t;
        seq_id <= id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // track where each type stands so most requests are in order
        if (t < NUM_TYPES && id >= stim_next[t])
            stim_next[t] = id + 1'b1;
    endtask

    task automatic send_random_request();
        int sel;
        int t;
        logic [ID_W-1:0] id;
        sel = $urandom_range(99);
        t = $urandom_range(NUM_TYPES - 1);
        if (sel < 55)
            id = stim_next[t];
        else if (sel < 67)
            id = stim_next[t] + ID_W'($urandom_range(12, 1));
        else if (sel < 77)
            id = (stim_next[t] == 0) ? '0 : ID_W'($urandom_range(stim_next[t] - 1));
        else if (sel < 82)
            id = ID_W'($urandom);
        else if (sel < 87)
            id = 16'hFFFF - ID_W'($urandom_range(2));
        else begin
            t = $urandom_range(15, NUM_TYPES);
            id = ID_W'($urandom);
        end
        send_request(TYPE_W'(t), id);
        random_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        pkt_type = '0;
        seq_id = '0;
        out_ready = 1'b0;
        stall_cycles = 0;
        directed_sent = 0;
        random_sent = 0;
        send_idle_pct = 20;
        recv_idle_pct = 73;
        for (int i = 0; i < NUM_TYPES; i++)
            stim_next[i] = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // duplicates, gaps, id wrap and every invalid type
        send_request(0, 16'h0000);
        send_request(0, 16'h0000);
        send_request(0, 16'h0005);
        send_request(0, 16'h0003);
        send_request(0, 16'h0006);
        send_request(1, 16'hFFFF);
        send_request(1, 16'h0000);
        send_request(1, 16'hFFFF);
        send_request(2, 16'h0001);
        send_request(2, 16'h0000);
        send_request(3, 16'h8000);
        send_request(3, 16'h7FFF);
        send_request(4, 16'hFFFE);
        send_request(4, 16'hFFFF);
        send_request(4, 16'h0000);
        send_request(5, 16'h0000);
        send_request(5, 16'h0000);
        directed_sent = 17;
        for (int t = NUM_TYPES; t < 16; t++) begin
            send_request(TYPE_W'(t), ID_W'($urandom));
            directed_sent++;
        end
        wait_for_drain();

        for (int p = 0; p < 3; p++) begin
            @(posedge clk);
            send_idle_pct = (p == 0) ? 20 : (p == 1) ? 73 : 0;
            recv_idle_pct = (p == 0) ? 73 : (p == 1) ? 20 : 0;
            for (int n = 0; n < 250; n++) begin
                send_random_request();
                if (n == 125)
                    wait_for_drain();
            end
            wait_for_drain();
        end

        wait_for_drain();
        repeat (10) @(posedge clk);
        $display("covered %0d directed and %0d random requests over three idle mixes",
                 directed_sent, random_sent);
        $display("with mid-run drains of the pipeline; %0d results checked", checked_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("tb_sequence_id_checker_core OK");
        else
            $display("tb_sequence_id_checker_core NOT OK");
        $finish;
    end

endmodule
